>>> hdl/scanline_polygon_span_fill_defines.svh
// Assertion macros shared by the polygon span filler.
`ifndef SCANLINE_POLYGON_SPAN_FILL_DEFINES_SVH
`define SCANLINE_POLYGON_SPAN_FILL_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SPF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span fill check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SPF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span fill check failed");

`endif

>>> hdl/spf_pkg.sv
`timescale 1ns / 1ps
// Constants, phase codes and controller/datapath bundles of the polygon span filler.
package spf_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int ROWS         = 1024;
  localparam int FRAC_BITS    = 16;
  localparam int RESULT_CAP   = 32;

  localparam int CW   = 10;                   // pixel coordinate width
  localparam int VAW  = $clog2(MAX_VERTICES); // vertex / edge address
  localparam int VCW  = VAW + 1;              // counts up to MAX_VERTICES
  localparam int XW   = CW + FRAC_BITS + 1;   // signed edge x
  localparam int SLW  = XW + 1;               // signed slope
  localparam int EW   = SLW + 2 * CW;         // slope, lower row, upper row
  localparam int NUMW = CW + FRAC_BITS;       // dividend of the slope
  localparam int DCW  = $clog2(NUMW);
  localparam int PXW  = SLW - FRAC_BITS;      // signed whole-pixel value
  localparam int RAW  = $clog2(RESULT_CAP);
  localparam int RCW  = RAW + 1;

  localparam int IN_TDW  = ((2 * CW + 7) / 8) * 8;
  localparam int OUT_TDW = ((3 * CW + 7) / 8) * 8;

  localparam logic [CW-1:0] XMAX = '1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_SCAN = 1'b1;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_FILL,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic load_vtx;
    logic build_start;
    logic first_latch;
    logic take_cur;
    logic k_adv;
    logic edge_begin;
    logic edge_write;
    logic set_done;
    logic join_start;
    logic sweep_start;
    logic pop;
    logic send_start;
    logic send_done;
    logic send_adv;
  } spf_cmd_t;

  typedef struct packed {
    phase_t phase;
    logic   vcnt_lt2;
    logic   k_last;
    logic   horiz;
    logic   div_busy;
    logic   etot_zero;
    logic   sweep_busy;
    logic   pair_busy;
    logic   out_last;
  } spf_stat_t;

endpackage

>>> hdl/spf_sorter.sv
`timescale 1ns / 1ps
// Insertion sort row of cells: one key enters sorted per cycle, the smallest leaves at cell 0.
module spf_sorter import spf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 ins,
  input  logic                 pop,
  input  logic signed [XW-1:0] key,
  output logic signed [XW-1:0] head
);

  logic signed [XW-1:0]    cell_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld_r;
  logic [MAX_VERTICES-1:0] lt;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      lt[i] = !vld_r[i] || (key < cell_r[i]);
    end
  end

  assign head = cell_r[0];

  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (clr) begin
          vld_r[g] <= 1'b0;
        end else if (ins) begin
          vld_r[g] <= 1'b1;
        end else if (pop) begin
          vld_r[g] <= vld_r[g+1];
        end
      end
      always_ff @(posedge clk) begin
        if (ins && lt[g]) begin
          cell_r[g] <= key;
        end else if (pop) begin
          cell_r[g] <= cell_r[g+1];
        end
      end
    end else if (g == MAX_VERTICES - 1) begin : g_last
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (clr) begin
          vld_r[g] <= 1'b0;
        end else if (ins) begin
          vld_r[g] <= vld_r[g] | vld_r[g-1];
        end else if (pop) begin
          vld_r[g] <= 1'b0;
        end
      end
      always_ff @(posedge clk) begin
        if (ins && lt[g]) begin
          cell_r[g] <= lt[g-1] ? cell_r[g-1] : key;
        end
      end
    end else begin : g_mid
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g] <= 1'b0;
        end else if (clr) begin
          vld_r[g] <= 1'b0;
        end else if (ins) begin
          vld_r[g] <= vld_r[g] | vld_r[g-1];
        end else if (pop) begin
          vld_r[g] <= vld_r[g+1];
        end
      end
      // shift right behind the insertion point, shift left on pop
      always_ff @(posedge clk) begin
        if (ins && lt[g]) begin
          cell_r[g] <= lt[g-1] ? cell_r[g-1] : key;
        end else if (pop) begin
          cell_r[g] <= cell_r[g+1];
        end
      end
    end
  end

endmodule

>>> hdl/spf_datapath.sv
`timescale 1ns / 1ps
// Datapath: vertex and edge stores, slope divider, edge sweep, span pairing and result buffer.
module spf_datapath import spf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  spf_cmd_t       cmd,
  output spf_stat_t      stat,
  input  logic [CW-1:0]  vtx_x,
  input  logic [CW-1:0]  vtx_y,
  output logic [CW-1:0]  span_y,
  output logic [CW-1:0]  span_xs,
  output logic [CW-1:0]  span_xe,
  output logic           span_valid,
  output logic           span_last,
  output logic           span_done
);

  phase_t         phase_r;
  logic [VCW-1:0] vcnt_r, k_r, k_nxt, etot_r, act_cnt_r, srt_n_r, vc_base;
  logic [CW-1:0]  row_r, ymin_r, served_r, y_sat;
  logic           k_last;

  logic [CW-1:0]  vmem_x [MAX_VERTICES];
  logic [CW-1:0]  vmem_y [MAX_VERTICES];
  logic [CW-1:0]  vrd_x_r, vrd_y_r, first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic [CW-1:0]  cur_x, cur_y;

  logic           lo_prev, dxneg;
  logic [CW-1:0]  xl, yl, xh, yh, dy, dxmag;
  logic [NUMW-1:0] num;
  logic [CW-1:0]  exl_r, eyl_r, eyh_r, ddy_r, rem_r, rem_nxt;
  logic           eneg_r, dbusy_r, ge;
  logic [NUMW-1:0] quo_r;
  logic [DCW-1:0] dcnt_r;
  logic [CW:0]    trial;
  logic signed [SLW-1:0] slope_w;

  logic signed [XW-1:0]  xmem [MAX_VERTICES];
  logic [EW-1:0]         smem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] active_r;
  logic                  iss_r, pv_r, adv_r, iss_last;
  logic [VAW-1:0]        iss_idx_r, pi_r;
  logic signed [XW-1:0]  xrd_r;
  logic [EW-1:0]         srd_r;
  logic signed [SLW-1:0] p_sl, xsum;
  logic [CW-1:0]         p_yl, p_yh;
  logic                  p_act, p_ins, p_ret, p_join, p_keep;
  logic                  x_we;
  logic [VAW-1:0]        x_wa;
  logic signed [XW-1:0]  x_wd;

  logic signed [XW-1:0]  head, pa_r;
  logic                  half_r, span_ok;
  logic signed [SLW-1:0] ceil_full;
  logic signed [PXW-1:0] s_px, e_px, s_cl, e_cl;
  logic [CW-1:0]         res_s_r [RESULT_CAP];
  logic [CW-1:0]         res_e_r [RESULT_CAP];
  logic [RCW-1:0]        nres_r;
  logic [RAW-1:0]        oidx_r;
  logic                  done_r, empty;

  // ---------------- vertex loading and edge setup ----------------
  assign vc_base = (phase_r != PH_LOAD) ? '0 : vcnt_r;
  assign y_sat   = (32'(vtx_y) >= 32'(ROWS)) ? CW'(ROWS - 1) : vtx_y;
  assign k_last  = k_r == vcnt_r;

  always_comb begin
    k_nxt = k_r;
    if (cmd.build_start) begin
      k_nxt = '0;
    end else if (cmd.k_adv) begin
      k_nxt = k_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vtx && (32'(vc_base) < 32'(MAX_VERTICES))) begin
      vmem_x[vc_base[VAW-1:0]] <= vtx_x;
      vmem_y[vc_base[VAW-1:0]] <= y_sat;
    end
    vrd_x_r <= vmem_x[k_nxt[VAW-1:0]];
    vrd_y_r <= vmem_y[k_nxt[VAW-1:0]];
  end

  assign cur_x = k_last ? first_x_r : vrd_x_r;
  assign cur_y = k_last ? first_y_r : vrd_y_r;

  always_comb begin
    lo_prev = prev_y_r < cur_y;
    xl      = lo_prev ? prev_x_r : cur_x;
    yl      = lo_prev ? prev_y_r : cur_y;
    xh      = lo_prev ? cur_x : prev_x_r;
    yh      = lo_prev ? cur_y : prev_y_r;
    dy      = yh - yl;
    dxneg   = xh < xl;
    dxmag   = dxneg ? (xl - xh) : (xh - xl);
    // round to nearest: add half the divisor before dividing
    num     = {dxmag, {FRAC_BITS{1'b0}}} + NUMW'(dy >> 1);
    trial   = {rem_r, quo_r[NUMW-1]};
    ge      = trial >= {1'b0, ddy_r};
    rem_nxt = ge ? CW'(trial - {1'b0, ddy_r}) : trial[CW-1:0];
    slope_w = eneg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  end

  // ---------------- edge sweep ----------------
  assign iss_last = ({1'b0, iss_idx_r} + 1'b1) == etot_r;

  always_comb begin
    p_sl   = $signed(srd_r[EW-1:2*CW]);
    p_yl   = srd_r[2*CW-1:CW];
    p_yh   = srd_r[CW-1:0];
    p_act  = active_r[pi_r];
    p_ins  = pv_r && adv_r && p_act;
    p_ret  = p_yh == row_r;
    p_keep = p_ins && !p_ret;
    p_join = pv_r && !p_act && (p_yl == row_r);
    xsum   = {xrd_r[XW-1], xrd_r} + p_sl;
    x_we   = 1'b0;
    x_wa   = pi_r;
    x_wd   = xsum[XW-1:0];
    if (cmd.edge_write) begin
      x_we = 1'b1;
      x_wa = etot_r[VAW-1:0];
      x_wd = $signed({1'b0, exl_r, {FRAC_BITS{1'b0}}});
    end else if (p_keep) begin
      x_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (x_we) begin
      xmem[x_wa] <= x_wd;
    end
    if (cmd.edge_write) begin
      smem[etot_r[VAW-1:0]] <= {slope_w, eyl_r, eyh_r};
    end
    if (iss_r) begin
      xrd_r <= xmem[iss_idx_r];
      srd_r <= smem[iss_idx_r];
    end
  end

  spf_sorter u_sorter (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (cmd.sweep_start),
    .ins   (p_ins),
    .pop   (cmd.pop),
    .key   (xrd_r),
    .head  (head)
  );

  // ---------------- span pairing ----------------
  always_comb begin
    ceil_full = {pa_r[XW-1], pa_r} + SLW'((1 << FRAC_BITS) - 1);
    s_px      = ceil_full[SLW-1:FRAC_BITS];
    e_px      = {head[XW-1], head[XW-1:FRAC_BITS]};
    s_cl      = (s_px < 0) ? '0 : s_px;
    e_cl      = (e_px > $signed(PXW'(XMAX))) ? $signed(PXW'(XMAX)) : e_px;
    span_ok   = cmd.pop && half_r && (s_cl <= e_cl) && (32'(nres_r) < 32'(RESULT_CAP));
  end

  always_ff @(posedge clk) begin
    if (span_ok) begin
      res_s_r[nres_r[RAW-1:0]] <= s_cl[CW-1:0];
      res_e_r[nres_r[RAW-1:0]] <= e_cl[CW-1:0];
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.first_latch) begin
      first_x_r <= vrd_x_r;
      first_y_r <= vrd_y_r;
      prev_x_r  <= vrd_x_r;
      prev_y_r  <= vrd_y_r;
    end else if (cmd.take_cur) begin
      prev_x_r  <= cur_x;
      prev_y_r  <= cur_y;
    end
    if (cmd.edge_begin) begin
      exl_r  <= xl;
      eyl_r  <= yl;
      eyh_r  <= yh;
      ddy_r  <= dy;
      eneg_r <= dxneg;
      quo_r  <= num;
      rem_r  <= '0;
    end else if (dbusy_r) begin
      quo_r  <= {quo_r[NUMW-2:0], ge};
      rem_r  <= rem_nxt;
    end
    if (cmd.pop && !half_r) begin
      pa_r <= head;
    end
    if (cmd.sweep_start) begin
      served_r <= row_r;
    end else if (cmd.send_done) begin
      served_r <= row_r;
    end
    pi_r <= iss_idx_r;
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LOAD;
      vcnt_r    <= '0;
      row_r     <= '0;
      k_r       <= '0;
      etot_r    <= '0;
      ymin_r    <= '1;
      dbusy_r   <= 1'b0;
      dcnt_r    <= '0;
      active_r  <= '0;
      iss_r     <= 1'b0;
      iss_idx_r <= '0;
      pv_r      <= 1'b0;
      adv_r     <= 1'b0;
      act_cnt_r <= '0;
      srt_n_r   <= '0;
      half_r    <= 1'b0;
      nres_r    <= '0;
      oidx_r    <= '0;
      done_r    <= 1'b0;
    end else begin
      k_r  <= k_nxt;
      pv_r <= iss_r;
      if (cmd.load_vtx) begin
        phase_r <= PH_LOAD;
        if (phase_r != PH_LOAD) begin
          row_r <= '0;
        end
        vcnt_r <= (32'(vc_base) < 32'(MAX_VERTICES)) ? vc_base + 1'b1 : vc_base;
      end
      if (cmd.build_start) begin
        etot_r   <= '0;
        ymin_r   <= '1;
        row_r    <= '0;
        active_r <= '0;
      end
      if (cmd.edge_begin) begin
        dbusy_r <= 1'b1;
        dcnt_r  <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == DCW'(NUMW - 1)) begin
          dbusy_r <= 1'b0;
        end
      end
      if (cmd.edge_write) begin
        etot_r <= etot_r + 1'b1;
        if (eyl_r < ymin_r) begin
          ymin_r <= eyl_r;
        end
      end
      if (cmd.set_done) begin
        phase_r <= PH_DONE;
      end
      if (cmd.join_start || cmd.sweep_start) begin
        iss_r     <= 1'b1;
        iss_idx_r <= '0;
        act_cnt_r <= '0;
        adv_r     <= cmd.sweep_start;
      end else if (iss_r) begin
        iss_idx_r <= iss_idx_r + 1'b1;
        if (iss_last) begin
          iss_r <= 1'b0;
        end
      end
      if (cmd.join_start) begin
        row_r   <= ymin_r;
        phase_r <= PH_FILL;
      end
      if (cmd.sweep_start) begin
        row_r   <= row_r + 1'b1;
        srt_n_r <= '0;
        half_r  <= 1'b0;
        nres_r  <= '0;
      end
      // retire, keep or join the edge read last cycle
      if (p_ins && p_ret) begin
        active_r[pi_r] <= 1'b0;
      end
      if (p_join) begin
        active_r[pi_r] <= 1'b1;
      end
      if ((p_keep || p_join) && !(cmd.join_start || cmd.sweep_start)) begin
        act_cnt_r <= act_cnt_r + 1'b1;
      end
      if (p_ins) begin
        srt_n_r <= srt_n_r + 1'b1;
      end else if (cmd.pop) begin
        srt_n_r <= srt_n_r - 1'b1;
        half_r  <= !half_r;
      end
      if (span_ok) begin
        nres_r <= nres_r + 1'b1;
      end
      if (cmd.send_done) begin
        nres_r <= '0;
        done_r <= 1'b1;
        oidx_r <= '0;
      end else if (cmd.send_start) begin
        done_r <= act_cnt_r == '0;
        oidx_r <= '0;
        if (act_cnt_r == '0) begin
          phase_r <= PH_DONE;
        end
      end else if (cmd.send_adv) begin
        oidx_r <= oidx_r + 1'b1;
      end
    end
  end

  // ---------------- result and status ----------------
  assign empty      = nres_r == '0;
  assign span_y     = served_r;
  assign span_xs    = empty ? '0 : res_s_r[oidx_r];
  assign span_xe    = empty ? '0 : res_e_r[oidx_r];
  assign span_valid = !empty;
  assign span_last  = empty || (({1'b0, oidx_r} + 1'b1) == nres_r);
  assign span_done  = done_r;

  always_comb begin
    stat.phase      = phase_r;
    stat.vcnt_lt2   = vcnt_r < VCW'(2);
    stat.k_last     = k_last;
    stat.horiz      = prev_y_r == cur_y;
    stat.div_busy   = dbusy_r;
    stat.etot_zero  = etot_r == '0;
    stat.sweep_busy = iss_r || pv_r;
    stat.pair_busy  = (srt_n_r >= VCW'(2)) || half_r;
    stat.out_last   = span_last;
  end

endmodule

>>> hdl/spf_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences vertex loading, edge table build, row sweep, pairing and result delivery.
module spf_ctrl import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      req_type,
  input  logic      out_tready,
  input  spf_stat_t stat,
  output logic      in_tready,
  output logic      out_tvalid,
  output spf_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BFIRST,
    ST_BNEXT,
    ST_BDIV,
    ST_BEND,
    ST_JOIN,
    ST_SWEEP,
    ST_PAIR,
    ST_SEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r, out_vld_r;

  assign in_tready  = in_rdy_r;
  assign out_tvalid = out_vld_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid && in_rdy_r) begin
          if (req_type == REQ_LOAD) begin
            cmd.load_vtx = 1'b1;
          end else begin
            unique case (stat.phase)
              PH_LOAD: begin
                cmd.build_start = 1'b1;
                state_nxt       = ST_BFIRST;
              end
              PH_FILL: begin
                cmd.sweep_start = 1'b1;
                state_nxt       = ST_SWEEP;
              end
              PH_DONE: begin
                cmd.send_done = 1'b1;
                state_nxt     = ST_SEND;
              end
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_BFIRST: begin
        if (stat.vcnt_lt2) begin
          state_nxt = ST_BEND;
        end else begin
          cmd.first_latch = 1'b1;
          cmd.k_adv       = 1'b1;
          state_nxt       = ST_BNEXT;
        end
      end
      ST_BNEXT: begin
        cmd.take_cur = 1'b1;
        if (!stat.horiz) begin
          cmd.edge_begin = 1'b1;
          state_nxt      = ST_BDIV;
        end else if (stat.k_last) begin
          state_nxt = ST_BEND;
        end else begin
          cmd.k_adv = 1'b1;
        end
      end
      ST_BDIV: begin
        if (!stat.div_busy) begin
          cmd.edge_write = 1'b1;
          if (stat.k_last) begin
            state_nxt = ST_BEND;
          end else begin
            cmd.k_adv = 1'b1;
            state_nxt = ST_BNEXT;
          end
        end
      end
      ST_BEND: begin
        if (stat.etot_zero) begin
          cmd.set_done  = 1'b1;
          cmd.send_done = 1'b1;
          state_nxt     = ST_SEND;
        end else begin
          cmd.join_start = 1'b1;
          state_nxt      = ST_JOIN;
        end
      end
      ST_JOIN: begin
        if (!stat.sweep_busy) begin
          cmd.sweep_start = 1'b1;
          state_nxt       = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!stat.sweep_busy) begin
          state_nxt = ST_PAIR;
        end
      end
      ST_PAIR: begin
        if (stat.pair_busy) begin
          cmd.pop = 1'b1;
        end else begin
          cmd.send_start = 1'b1;
          state_nxt      = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_vld_r && out_tready) begin
          if (stat.out_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.send_adv = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      in_rdy_r  <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      in_rdy_r  <= state_nxt == ST_IDLE;
      out_vld_r <= state_nxt == ST_SEND;
    end
  end

endmodule

>>> hdl/scanline_polygon_span_fill.sv
`timescale 1ns / 1ps
// A vertex load leaves the block ready for the next request. A scanline request runs from accept
// to ready again through the edge sweep over all E stored edges (one memory read a cycle), the
// sorter pops and the results out, and output stalls can hold it. One request is worked on at a
// time. The first request after loading adds the edge build, which runs the bit-serial slope
// divider once for each non-horizontal edge.
// Reset (rst_n low, synchronous) clears counts and phase; the stores keep their contents.
module scanline_polygon_span_fill import spf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,   // vertex_x, vertex_y, zero pad
  input  logic [0:0]         in_tuser,   // req_type
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_TDW-1:0] out_tdata,  // span_y, span_x_start, span_x_end, zero pad
  output logic               out_tlast,
  output logic [1:0]         out_tuser   // span_valid, fill_done
);

  `include "scanline_polygon_span_fill_defines.svh"

  spf_cmd_t      cmd;
  spf_stat_t     stat;
  logic [CW-1:0] span_y, span_xs, span_xe;
  logic          span_valid, span_last, span_done;

  spf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .req_type   (in_tuser[0]),
    .out_tready (out_tready),
    .stat       (stat),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  spf_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .vtx_x      (in_tdata[CW-1:0]),
    .vtx_y      (in_tdata[2*CW-1:CW]),
    .span_y     (span_y),
    .span_xs    (span_xs),
    .span_xe    (span_xe),
    .span_valid (span_valid),
    .span_last  (span_last),
    .span_done  (span_done)
  );

  assign out_tdata = {{(OUT_TDW - 3 * CW){1'b0}}, span_xe, span_xs, span_y};
  assign out_tlast = span_last;
  assign out_tuser = {span_done, span_valid};

  `SPF_ASSERT_IMP(a_no_overlap, in_tready, !out_tvalid)
  `SPF_ASSERT_NXT(a_sweep_runs, cmd.sweep_start, stat.sweep_busy)
  `SPF_ASSERT_NXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)

endmodule

>>> tb/scanline_polygon_span_fill_checker.sv
`timescale 1ns / 1ps
// Span predictor and result checker for the polygon span filler.
module scanline_polygon_span_fill_checker import spf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [IN_TDW-1:0]  in_tdata,
  input  logic [0:0]         in_tuser,
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [OUT_TDW-1:0] out_tdata,
  input  logic               out_tlast,
  input  logic [1:0]         out_tuser,
  output int                 err_count,
  output int                 pending
);

  typedef struct {
    logic [CW-1:0] row;
    logic [CW-1:0] xs;
    logic [CW-1:0] xe;
    logic          has_span;
    logic          last;
    logic          done;
  } span_t;

  span_t span_q[$];

  logic [CW-1:0] vtx_x[MAX_VERTICES];
  logic [CW-1:0] vtx_y[MAX_VERTICES];
  int            vtx_cnt;
  longint        edge_x[MAX_VERTICES];
  longint        edge_dx[MAX_VERTICES];
  int            edge_lo[MAX_VERTICES];
  int            edge_hi[MAX_VERTICES];
  int            edge_cnt;
  int            act[MAX_VERTICES];
  int            act_cnt;
  int            row;
  phase_t        phase;

  assign pending = span_q.size();

  function automatic longint px_floor(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic void join_edges(int r);
    for (int i = 0; i < edge_cnt; i++)
      if (edge_lo[i] == r && act_cnt < MAX_VERTICES) begin
        act[act_cnt] = i;
        act_cnt++;
      end
  endfunction

  function automatic void build_edge_table();
    int j, xl, yl, xh, yh, dy;
    longint dx, mag, q;
    edge_cnt = 0;
    for (int i = 0; i < vtx_cnt; i++) begin
      j = (i + 1 == vtx_cnt) ? 0 : i + 1;
      if (vtx_y[i] == vtx_y[j]) continue;
      if (vtx_y[i] < vtx_y[j]) begin
        xl = vtx_x[i]; yl = vtx_y[i]; xh = vtx_x[j]; yh = vtx_y[j];
      end else begin
        xl = vtx_x[j]; yl = vtx_y[j]; xh = vtx_x[i]; yh = vtx_y[i];
      end
      dy = yh - yl;
      dx = longint'(xh) - longint'(xl);
      mag = (dx < 0 ? -dx : dx) << FRAC_BITS;
      q = (mag + dy / 2) / dy;
      edge_x[edge_cnt]  = longint'(xl) << FRAC_BITS;
      edge_dx[edge_cnt] = dx < 0 ? -q : q;
      edge_lo[edge_cnt] = yl;
      edge_hi[edge_cnt] = yh;
      edge_cnt++;
    end
  endfunction

  // Work out the spans of one scanline request and queue them.
  function automatic void predict_scanline();
    span_t  res[RESULT_CAP];
    int     n, j, e, lo, served;
    longint s, f;
    n = 0;
    if (phase == PH_LOAD) begin
      build_edge_table();
      act_cnt = 0;
      row = 0;
      if (edge_cnt == 0) phase = PH_DONE;
      else begin
        lo = edge_lo[0];
        for (int i = 1; i < edge_cnt; i++)
          if (edge_lo[i] < lo) lo = edge_lo[i];
        row = lo;
        join_edges(lo);
        phase = PH_FILL;
      end
    end
    if (phase == PH_DONE) begin
      res[0] = '{row[CW-1:0], '0, '0, 1'b0, 1'b1, 1'b1};
      span_q.insert(span_q.size(), res[0]);
      return;
    end
    for (int i = 1; i < act_cnt; i++) begin
      e = act[i];
      j = i;
      while (j > 0 && edge_x[act[j-1]] > edge_x[e]) begin
        act[j] = act[j-1];
        j--;
      end
      act[j] = e;
    end
    served = row;
    for (int i = 0; i + 1 < act_cnt; i += 2) begin
      s = -px_floor(-edge_x[act[i]]);
      f = px_floor(edge_x[act[i+1]]);
      if (s < 0) s = 0;
      if (f > longint'(XMAX)) f = longint'(XMAX);
      if (s <= f && n < RESULT_CAP) begin
        res[n] = '{served[CW-1:0], s[CW-1:0], f[CW-1:0], 1'b1, 1'b0, 1'b0};
        n++;
      end
    end
    row++;
    j = 0;
    for (int i = 0; i < act_cnt; i++) begin
      e = act[i];
      if (edge_hi[e] != row) begin
        edge_x[e] += edge_dx[e];
        act[j] = e;
        j++;
      end
    end
    act_cnt = j;
    join_edges(row);
    if (act_cnt == 0) phase = PH_DONE;
    if (n == 0) begin
      res[0] = '{served[CW-1:0], '0, '0, 1'b0, 1'b0, 1'b0};
      n = 1;
    end
    res[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      res[k].done = (phase == PH_DONE);
      span_q.insert(span_q.size(), res[k]);
    end
  endfunction

  function automatic void take_vertex(logic [CW-1:0] x, logic [CW-1:0] y);
    if (phase != PH_LOAD) begin
      vtx_cnt = 0;
      act_cnt = 0;
      row = 0;
      phase = PH_LOAD;
    end
    if (vtx_cnt < MAX_VERTICES) begin
      vtx_x[vtx_cnt] = x;
      vtx_y[vtx_cnt] = y;
      vtx_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    span_t exp_s;
    if (!rst_n) begin
      span_q.delete();
      vtx_cnt = 0;
      edge_cnt = 0;
      act_cnt = 0;
      row = 0;
      phase = PH_LOAD;
      err_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (span_q.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: unexpected result tdata=%h tlast=%b tuser=%b",
                     $realtime, out_tdata, out_tlast, out_tuser);
        end else begin
          exp_s = span_q.pop_front();
          if (out_tdata[CW-1:0] !== exp_s.row || out_tdata[2*CW-1:CW] !== exp_s.xs ||
              out_tdata[3*CW-1:2*CW] !== exp_s.xe || out_tuser[0] !== exp_s.has_span ||
              out_tlast !== exp_s.last || out_tuser[1] !== exp_s.done) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: span mismatch exp y=%0d xs=%0d xe=%0d v=%b last=%b done=%b",
                        " got y=%0d xs=%0d xe=%0d v=%b last=%b done=%b"}, $realtime,
                       exp_s.row, exp_s.xs, exp_s.xe, exp_s.has_span, exp_s.last,
                       exp_s.done, out_tdata[CW-1:0], out_tdata[2*CW-1:CW],
                       out_tdata[3*CW-1:2*CW], out_tuser[0], out_tlast, out_tuser[1]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == REQ_SCAN) predict_scanline();
        else take_vertex(in_tdata[CW-1:0], in_tdata[2*CW-1:CW]);
      end
    end
  end

endmodule

>>> tb/scanline_polygon_span_fill_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the polygon span filler.
module scanline_polygon_span_fill_tb import spf_pkg::*;;

  localparam int CYCLE_LIMIT = 600000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_TDW-1:0]  in_tdata = '0;
  logic [0:0]         in_tuser = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_TDW-1:0] out_tdata;
  logic               out_tlast;
  logic [1:0]         out_tuser;
  int                 err_count;
  int                 pending;
  int                 cycles = 0;
  int                 sent = 0;
  bit                 steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scanline_polygon_span_fill DUT (.*);

  scanline_polygon_span_fill_checker span_check (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    out_tready <= steady || ($urandom_range(99) >= 6);
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_request(logic req, int x, int y);
    while (!steady && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0, y[CW-1:0], x[CW-1:0]};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  task automatic drain_spans();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Load a random polygon inside a short band of rows, then request scanlines.
  task automatic fill_polygon(int nv, int height);
    int base_y, y;
    base_y = $urandom_range(1023);
    for (int i = 0; i < nv; i++) begin
      y = base_y + $urandom_range(height);
      if (y > 1023) y = 1023;
      send_request(REQ_LOAD, $urandom_range(1023), y);
    end
    repeat ($urandom_range(height + 4)) send_request(REQ_SCAN, $urandom, $urandom);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // scan with nothing loaded, then a single vertex
    send_request(REQ_SCAN, 0, 0);
    send_request(REQ_LOAD, 0, 0);
    send_request(REQ_SCAN, 1023, 1023);
    // triangle at the top rows and right edge, with a horizontal edge
    send_request(REQ_LOAD, 0, 1016);
    send_request(REQ_LOAD, 1023, 1023);
    send_request(REQ_LOAD, 1023, 1016);
    repeat (9) send_request(REQ_SCAN, 0, 0);
    // only horizontal edges
    send_request(REQ_LOAD, 5, 7);
    send_request(REQ_LOAD, 9, 7);
    send_request(REQ_SCAN, 0, 0);
    // triangle scanned for two rows, then a new polygon loaded while it is still filling
    send_request(REQ_LOAD, 3, 2);
    send_request(REQ_LOAD, 40, 12);
    send_request(REQ_LOAD, 1, 9);
    send_request(REQ_SCAN, 0, 0);
    send_request(REQ_SCAN, 0, 0);
    send_request(REQ_LOAD, 700, 0);
    drain_spans();

    fill_polygon(68, 5);
    while (sent < 470) begin
      if (sent > 200 && sent < 260) steady = 1'b1;
      else steady = 1'b0;
      if ($urandom_range(9) == 0)
        send_request(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023));
      else
        fill_polygon($urandom_range(2, 9), $urandom_range(1, 14));
      if ($urandom_range(15) == 0) drain_spans();
    end
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (err_count == 0 && pending == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
